// ----- hw/rtl/rbd_pkg.sv -----
// Shared types, constants and channel arithmetic for the 2x2 RGBA downsampler.
package rbd_pkg;

  localparam int CHAN_BITS         = 8;
  localparam int SUM_BITS          = CHAN_BITS + 1;
  localparam int SRC_WIDTH_BITS    = 10;
  localparam int MAX_WIDTH_DEFAULT = 512;

  localparam logic [SRC_WIDTH_BITS-1:0] SRC_WIDTH_RESET = SRC_WIDTH_BITS'(512);

  // Register index codes, taken from byte address bit 2.
  localparam logic [0:0] REG_SOURCE_WIDTH = 1'b0;

  typedef struct packed {
    logic [CHAN_BITS-1:0] alpha;
    logic [CHAN_BITS-1:0] blue;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] alpha;
    logic [SUM_BITS-1:0] blue;
    logic [SUM_BITS-1:0] green;
    logic [SUM_BITS-1:0] red;
  } pair_sum_t;

  typedef struct packed {
    logic      valid;
    logic      row_end;
    pair_sum_t sums;
  } pair_word_t;

  function automatic pair_sum_t pair_add(pixel_t a, pixel_t b);
    pair_sum_t s;
    s.red   = SUM_BITS'(a.red)   + SUM_BITS'(b.red);
    s.green = SUM_BITS'(a.green) + SUM_BITS'(b.green);
    s.blue  = SUM_BITS'(a.blue)  + SUM_BITS'(b.blue);
    s.alpha = SUM_BITS'(a.alpha) + SUM_BITS'(b.alpha);
    return s;
  endfunction

  function automatic logic [CHAN_BITS-1:0] quad_avg(logic [SUM_BITS-1:0] lo,
                                                    logic [SUM_BITS-1:0] hi);
    logic [SUM_BITS:0] t;
    t = (SUM_BITS+1)'(lo) + (SUM_BITS+1)'(hi);
    return t[SUM_BITS:2];
  endfunction

  function automatic pixel_t block_avg(pair_sum_t lo, pair_sum_t hi);
    pixel_t p;
    p.red   = quad_avg(lo.red,   hi.red);
    p.green = quad_avg(lo.green, hi.green);
    p.blue  = quad_avg(lo.blue,  hi.blue);
    p.alpha = quad_avg(lo.alpha, hi.alpha);
    return p;
  endfunction

endpackage

// ----- hw/rtl/rbd_line_store.sv -----
// Line store of horizontal pair sums, one write port and one registered read port.
module rbd_line_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  rbd_pkg::pair_sum_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output rbd_pkg::pair_sum_t rd_data
);
  import rbd_pkg::*;

  pair_sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/rbd_pair_stage.sv -----
// Input stage: column and row tracking, held left pixel, pair sums and line store access.
module rbd_pair_stage #(
  parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEFAULT,
  localparam int AW = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH) - 1 : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rbd_pkg::SRC_WIDTH_BITS-1:0] source_width,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  rbd_pkg::pixel_t                    pixel,
  input  logic                               s1_take,
  output rbd_pkg::pair_word_t                s1,
  output logic                               row_odd,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output rbd_pkg::pair_sum_t                 wr_data,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr
);
  import rbd_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > SRC_WIDTH_BITS) ? CW + 1 : SRC_WIDTH_BITS;
  localparam logic [WW-1:0] WIDTH_CAP = WW'(MAX_WIDTH - (MAX_WIDTH % 2));

  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [CW-1:0] col_half;
  logic          odd_row;
  pixel_t        held;
  logic          s1_valid;
  logic          s1_row_end;
  pair_sum_t     s1_sums;
  logic [WW-1:0] width_eff;
  logic [WW-1:0] col_plus;
  logic          row_last;
  logic          accept;
  pair_sum_t     sums;

  // Even width with saturation at the line capacity; zero means two.
  always_comb begin
    width_eff = WW'({source_width[SRC_WIDTH_BITS-1:1], 1'b0});
    if (width_eff > WIDTH_CAP) begin
      width_eff = WIDTH_CAP;
    end
    if (width_eff == '0) begin
      width_eff = WW'(2);
    end
  end

  assign col_plus  = WW'(col) + WW'(1);
  assign row_last  = (col_plus >= width_eff);
  assign col_next  = row_last ? '0 : col_plus[CW-1:0];
  assign col_half  = col >> 1;
  assign pix_stall = s1_valid && !s1_take;
  assign accept    = pix_valid && !pix_stall;
  assign sums      = pair_add(held, pixel);

  assign wr_en   = accept && col[0] && !odd_row;
  assign wr_addr = col_half[AW-1:0];
  assign wr_data = sums;
  assign rd_en   = accept && !col[0] && odd_row;
  assign rd_addr = col_half[AW-1:0];

  assign row_odd    = odd_row;
  assign s1.valid   = s1_valid;
  assign s1.row_end = s1_row_end;
  assign s1.sums    = s1_sums;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      odd_row  <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        col      <= col_next;
        odd_row  <= odd_row ^ row_last;
        s1_valid <= col[0] && odd_row;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      held <= pixel;
    end
    if (accept && col[0]) begin
      s1_sums    <= sums;
      s1_row_end <= row_last;
    end
  end

endmodule

// ----- hw/rtl/rbd_avg_stage.sv -----
// Output stage: adds the pair sum from the line above and registers the averaged word.
module rbd_avg_stage (
  input  logic                clk,
  input  logic                rst,
  input  rbd_pkg::pair_word_t s1,
  input  rbd_pkg::pair_sum_t  above,
  output logic                s1_take,
  output logic                mip_valid,
  input  logic                mip_stall,
  output rbd_pkg::pixel_t     mip_pixel,
  output logic                row_end
);
  import rbd_pkg::*;

  assign s1_take = !mip_valid || !mip_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mip_valid <= 1'b0;
    end else if (s1_take) begin
      mip_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1.valid) begin
      mip_pixel <= block_avg(s1.sums, above);
      row_end   <= s1.row_end;
    end
  end

endmodule

// ----- hw/rtl/rgba_box_downsample_2x2.sv -----
// Top level of the 2x2 box-filter RGBA mip downsampler with its register port.
// Pipeline: the odd-row, odd-column pixel that completes a 2x2 block is registered
//   in the front stage, and its averaged word then in the output register.
// Throughput: one source pixel per cycle while the sink keeps up (combinational pair
//   adder, one-write one-read line store); at most one output word per two pixels.
// Reset clears column, row parity and both pipeline valids; source_width resets to 512.
module rgba_box_downsample_2x2 #(
  parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Source pixel channel
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  // Downsampled pixel channel
  output logic        mip_valid,
  input  logic        mip_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  alpha_out,
  output logic        row_end
);
  import rbd_pkg::*;

  // The line store holds one pair sum per output column of the widest row.
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW         = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH) - 1 : 1;

  logic [SRC_WIDTH_BITS-1:0] source_width;
  logic                      cfg_write;
  pixel_t                    src_pixel;
  pixel_t                    mip_pixel;
  pair_word_t                s1;
  logic                      s1_take;
  logic                      row_odd;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  pair_sum_t                 wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  pair_sum_t                 above;

  // The register port never waits. Bit 2 of the byte address selects the register;
  // writes to any address other than source_width are dropped.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= SRC_WIDTH_RESET;
    end else if (cfg_write && (paddr[2] == REG_SOURCE_WIDTH)) begin
      source_width <= pwdata[SRC_WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SOURCE_WIDTH) begin
      prdata = 32'(source_width);
    end
  end

  assign src_pixel.red   = red_in;
  assign src_pixel.green = green_in;
  assign src_pixel.blue  = blue_in;
  assign src_pixel.alpha = alpha_in;

  // Front stage: tracks the column and row parity, holds the left pixel of each
  // pair, writes pair sums on even rows and fetches the sum from above on odd rows.
  // The fetch is issued with the left pixel, so the registered read data is ready
  // when the right pixel completes the block.
  rbd_pair_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pair (
    .clk          (clk),
    .rst          (rst),
    .source_width (source_width),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel        (src_pixel),
    .s1_take      (s1_take),
    .s1           (s1),
    .row_odd      (row_odd),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  rbd_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (above)
  );

  // Output stage: completes the four-pixel sum, divides by four and registers the
  // word. It acts as the skid register, so the front keeps taking pixels while a
  // finished word waits for the sink.
  rbd_avg_stage u_avg (
    .clk       (clk),
    .rst       (rst),
    .s1        (s1),
    .above     (above),
    .s1_take   (s1_take),
    .mip_valid (mip_valid),
    .mip_stall (mip_stall),
    .mip_pixel (mip_pixel),
    .row_end   (row_end)
  );

  assign red_out   = mip_pixel.red;
  assign green_out = mip_pixel.green;
  assign blue_out  = mip_pixel.blue;
  assign alpha_out = mip_pixel.alpha;

  // The source is held off only when both the front register and the output
  // register are full and the sink is stalling.
  assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (s1.valid && mip_valid && mip_stall))
    else $error("source stalled while the pipeline had room");

  // Nothing leaves the block right after reset.
  assert property (@(posedge clk)
    rst |=> !mip_valid)
    else $error("output word valid after reset");

  // A pixel of an even source row never produces a word.
  assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall && !row_odd) |=> !s1.valid)
    else $error("even-row pixel produced a word");

  // A word handed on by the front stage lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1_take) |=> mip_valid)
    else $error("word lost between front and output stage");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the 2x2 box-filter RGBA mip downsampler.
`timescale 1ns / 100ps

module testbench;
  import rbd_pkg::*;

  // The block is built with its default line store size.
  localparam int MAX_WIDTH  = MAX_WIDTH_DEFAULT;
  localparam int LINE_SLOTS = MAX_WIDTH / 2;
  // Widest row the block can run; an odd parameter is rounded down to even.
  localparam int WIDTH_CAP  = MAX_WIDTH - MAX_WIDTH % 2;

  // Register index one past the end of the register list; writes to it must be ignored.
  localparam logic [0:0] REG_SPARE = 1'b1;

  // The output register sits behind the front register, so DRAIN_CYCLES quiet
  // cycles are enough for anything still in the pipeline to drain.
  localparam int DRAIN_CYCLES = 6;
  // Cycles with no handshake on any port before the run is declared hung.
  localparam int HANG_LIMIT   = 4000;

  // One expected downsampled word.
  typedef struct {
    pixel_t px;
    logic   row_end;
  } mip_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        pix_valid;
  logic        pix_stall;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  alpha_in;
  logic        mip_valid;
  logic        mip_stall;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  alpha_out;
  logic        row_end;

  // Idle and stall rates in percent, changed from phase to phase.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  int error_count    = 0;
  int quiet_cycles   = 0;
  int mip_words_seen = 0;

  // Downsampler state as the testbench sees it, updated on every accepted
  // source word and every write to the width register.
  logic [9:0] pred_width_reg = SRC_WIDTH_RESET;
  int         pred_column    = 0;
  logic       pred_odd_row   = 1'b0;
  pixel_t     pred_held      = '0;
  pair_sum_t  pred_pair_line [LINE_SLOTS];

  // Output words still owed by the block, oldest first.
  mip_word_t  pending_mip_words [$];

  rgba_box_downsample_2x2 i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .mip_valid (mip_valid),
    .mip_stall (mip_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .row_end   (row_end)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random; the rate is set by the current phase.
  always @(negedge clk) begin
    mip_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Every mismatch goes through here so that it is printed once and counted.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d field %s: got %0d, expected %0d",
                                mip_words_seen, name, got, want));
    end
  endtask

  // Row width the block actually runs: bit 0 dropped, capped at the line
  // store size, and a zero width treated as two.
  function automatic int effective_width();
    int w;
    w = int'(pred_width_reg & 10'h3FE);
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    if (w == 0) w = 2;
    return w;
  endfunction

  // Advances the state by one source word. Even rows leave pair sums in the
  // line store; on odd rows every second pixel closes a 2x2 block, whose
  // truncated average per channel is queued as the next output word.
  task automatic compute_mip_word(input pixel_t px);
    int        w;
    int        slot;
    int        k;
    pair_sum_t sums;
    pair_sum_t above;
    logic [9:0] total;
    mip_word_t word;
    w    = effective_width();
    slot = (pred_column / 2) % LINE_SLOTS;
    if (pred_column % 2 == 0) begin
      pred_held = px;
    end else begin
      for (k = 0; k < 4; k++) begin
        sums[9*k +: 9] = {1'b0, pred_held[8*k +: 8]} + {1'b0, px[8*k +: 8]};
      end
      if (!pred_odd_row) begin
        pred_pair_line[slot] = sums;
      end else begin
        above = pred_pair_line[slot];
        for (k = 0; k < 4; k++) begin
          total = {1'b0, sums[9*k +: 9]} + {1'b0, above[9*k +: 9]};
          word.px[8*k +: 8] = total[9:2];
        end
        word.row_end = (pred_column + 1 >= w);
        pending_mip_words.push_back(word);
      end
    end
    // A column at or past the width closes the row, which also covers a
    // width that was narrowed in the middle of a row.
    if (pred_column + 1 >= w) begin
      pred_column  = 0;
      pred_odd_row = ~pred_odd_row;
    end else begin
      pred_column++;
    end
  endtask

  // Output checker: every word the block hands over is compared, field by
  // field, with the oldest word still owed.
  always @(posedge clk) begin
    if (!rst && mip_valid && !mip_stall) begin
      if (pending_mip_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", mip_words_seen));
      end else begin
        mip_word_t want;
        want = pending_mip_words.pop_front();
        check_field("red_out",   red_out,   want.px.red);
        check_field("green_out", green_out, want.px.green);
        check_field("blue_out",  blue_out,  want.px.blue);
        check_field("alpha_out", alpha_out, want.px.alpha);
        check_field("row_end",   row_end,   want.row_end);
      end
      mip_words_seen++;
    end
  end

  // Watchdog: any handshake on any port counts as progress. A run that goes
  // quiet for too long, including one still owing words at the end, fails.
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (mip_valid && !mip_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Channel values lean on the extremes so that carries and truncation at
  // both ends come up often.
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = rand_channel();
    px.green = rand_channel();
    px.blue  = rand_channel();
    px.alpha = rand_channel();
    return px;
  endfunction

  // Sends one source word. Inputs move only at the falling edge; valid stays
  // high after acceptance, so back-to-back words stream without a gap unless
  // the sender decides to idle.
  task automatic push_pixel(input pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    red_in    <= px.red;
    green_in  <= px.green;
    blue_in   <= px.blue;
    alpha_in  <= px.alpha;
    do @(posedge clk); while (pix_stall);
    compute_mip_word(px);
  endtask

  task automatic push_random_pixels(input int count);
    repeat (count) push_pixel(rand_pixel());
  endtask

  // Stops the source, waits for every owed word, then lets the pipeline
  // drain, since even-row words leave nothing to wait for.
  task automatic wait_idle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_mip_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes and reads each go through a setup phase and an access phase.
  task automatic apb_write(input logic [0:0] index, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_SOURCE_WIDTH) pred_width_reg = data[9:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [0:0] index, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {index, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads the width register back and compares it with what was written last.
  task automatic check_width_reg();
    logic [31:0] readback;
    apb_read(REG_SOURCE_WIDTH, readback);
    if (readback !== {22'b0, pred_width_reg}) begin
      report_mismatch($sformatf("source_width read back 0x%0h, expected 0x%0h",
                                readback, pred_width_reg));
    end
  endtask

  // Changes the width once the block has gone quiet. Upper data bits are
  // random, since only the low ten bits belong to the register.
  task automatic set_width(input logic [9:0] value);
    logic [31:0] data;
    data       = $urandom();
    data[9:0]  = value;
    wait_idle();
    apb_write(REG_SOURCE_WIDTH, data);
    check_width_reg();
  endtask

  // Pads the current image out to its end so the next test starts at row 0.
  task automatic finish_image();
    while (pred_column != 0 || pred_odd_row) push_pixel(rand_pixel());
  endtask

  // Full-width image. The even row runs at the reset width and fills every
  // line store entry, so no later row can read an entry never written. The
  // odd row runs with the register at its top value, which must saturate to
  // the line store size and end the output row exactly there.
  task automatic test_reset_and_saturated_width();
    src_idle_pct   = 36;
    sink_stall_pct = 36;
    check_width_reg();
    push_random_pixels(WIDTH_CAP);
    set_width(10'h3FF);
    push_random_pixels(WIDTH_CAP);
  endtask

  // Narrowest rows: a register value of zero, and of one, both act as width
  // two. The blocks hit all-ones sums and truncation of the quarter at both
  // ends of the range. A write past the register list must change nothing.
  task automatic test_tiny_widths_and_rounding();
    logic [31:0] junk;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_width(10'd0);
    repeat (4) push_pixel('{alpha: 8'hFF, blue: 8'hFF, green: 8'hFF, red: 8'hFF});
    set_width(10'd1);
    push_pixel('{alpha: 8'd128, blue: 8'd0, green: 8'd255, red: 8'd1});
    push_pixel('{alpha: 8'd129, blue: 8'd0, green: 8'd255, red: 8'd1});
    push_pixel('{alpha: 8'd130, blue: 8'd0, green: 8'd255, red: 8'd1});
    push_pixel('{alpha: 8'd131, blue: 8'd0, green: 8'd254, red: 8'd0});
    junk = $urandom();
    wait_idle();
    apb_write(REG_SPARE, junk);
    check_width_reg();
  endtask

  // Width changes in the middle of a row take effect at once. On an odd row
  // the narrower width turns the next result into the row's last; on an
  // even row the column already lies past the new width, so the row closes
  // with the very next pixel.
  task automatic test_width_change_mid_row();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    finish_image();
    set_width(10'd8);
    push_random_pixels(8);
    push_random_pixels(5);
    set_width(10'd4);
    push_random_pixels(1);
    push_random_pixels(3);
    set_width(10'd2);
    push_random_pixels(1);
  endtask

  // An image that stops after an even row leaves nothing to emit.
  task automatic test_odd_height();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    finish_image();
    set_width(10'd4);
    push_random_pixels(4);
    wait_idle();
  endtask

  // Random images of mostly narrow widths, with odd and zero register values
  // among them, now and then a wider row, and now and then a stream cut off
  // mid-row before the next width change.
  task automatic test_random_stream(input int idle_pct, input int stall_pct, input int items);
    int sent;
    int w;
    int count;
    logic [9:0] value;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) value = 10'($urandom_range(41, 100));
      else value = 10'($urandom_range(0, 40));
      set_width(value);
      w = effective_width();
      if ($urandom_range(4) == 0) count = $urandom_range(1, 2 * w);
      else if (w > 40) count = 2 * w;
      else count = 2 * w * $urandom_range(1, 3);
      push_random_pixels(count);
      sent += count;
    end
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    pix_valid = 1'b0;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    alpha_in  = '0;
    mip_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_and_saturated_width();
    test_tiny_widths_and_rounding();
    test_width_change_mid_row();
    test_odd_height();
    test_random_stream(0, 0, 100);
    test_random_stream(49, 0, 100);
    test_random_stream(0, 49, 100);
    test_random_stream(36, 36, 100);

    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_line_store.sv
hw/rtl/rbd_pair_stage.sv
hw/rtl/rbd_avg_stage.sv
hw/rtl/rgba_box_downsample_2x2.sv
verif/testbench.sv
